// ----- hw/rtl/ptsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsu_pkg
// Shared types and constants of the polynomial term splitter.
// ----------------------------------------------------------------------------
package ptsu_pkg;

  localparam int POS_W  = 11;
  localparam int TO_W   = 10;
  localparam int LVL_W  = 8;
  localparam int STAT_W = 2;

  localparam int MAX_LEN   = 1024;
  localparam int MAX_DEPTH = 255;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_MALFORMED = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]  term_from;
    logic [TO_W-1:0]   term_to;
    logic              term_negative;
    logic [LVL_W-1:0]  term_depth;
    logic              word_done;
    logic [STAT_W-1:0] status;
    logic [LVL_W-1:0]  word_depth;
  } rec_t;

  typedef struct packed {
    logic [1:0] cnt;
    rec_t       a;
    rec_t       b;
  } push_t;

endpackage

// ----- hw/rtl/ptsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsu_front
// Scans one character per cycle while the queue has room, tracks nesting and
// term bounds, and emits zero, one or two result records toward the queue.
// ----------------------------------------------------------------------------
module ptsu_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_ch,
  input  logic                in_last,
  input  logic                room,
  output ptsu_pkg::push_t     push
);

  logic [ptsu_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [ptsu_pkg::LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [ptsu_pkg::POS_W-1:0]  start_r, start_nxt;
  logic                        neg_r, neg_nxt;
  logic [ptsu_pkg::LVL_W-1:0]  tdep_r, tdep_nxt;
  logic [ptsu_pkg::LVL_W-1:0]  deep_r, deep_nxt;
  logic [ptsu_pkg::STAT_W-1:0] err_r, err_nxt;
  logic                        accept;
  logic                        is_sign;
  logic [ptsu_pkg::LVL_W-1:0]  wd;
  ptsu_pkg::rec_t              rec;
  ptsu_pkg::push_t             p;

  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign is_sign  = (in_ch == ptsu_pkg::CH_PLUS) || (in_ch == ptsu_pkg::CH_MINUS);

  always_comb begin
    pos_nxt   = pos_r;
    lvl_nxt   = lvl_r;
    start_nxt = start_r;
    neg_nxt   = neg_r;
    tdep_nxt  = tdep_r;
    deep_nxt  = deep_r;
    err_nxt   = err_r;
    wd        = '0;
    rec       = '0;
    p         = '0;
    if (err_r == ptsu_pkg::ST_OK) begin
      if (pos_r >= ptsu_pkg::POS_W'(ptsu_pkg::MAX_LEN)) begin
        err_nxt = ptsu_pkg::ST_OVERFLOW;
      end else begin
        if (pos_r == '0 && is_sign) begin
          start_nxt = ptsu_pkg::POS_W'(1);
          neg_nxt   = (in_ch == ptsu_pkg::CH_MINUS);
        end else if (in_ch == ptsu_pkg::CH_LPAREN) begin
          if (lvl_r >= ptsu_pkg::LVL_W'(ptsu_pkg::MAX_DEPTH)) begin
            err_nxt = ptsu_pkg::ST_OVERFLOW;
          end else begin
            lvl_nxt = lvl_r + 1'b1;
            if (tdep_r < lvl_nxt) begin
              tdep_nxt = lvl_nxt;
            end
          end
        end else if (in_ch == ptsu_pkg::CH_RPAREN) begin
          if (lvl_r == '0) begin
            err_nxt = ptsu_pkg::ST_MALFORMED;
          end else begin
            lvl_nxt = lvl_r - 1'b1;
          end
        end else if (lvl_r == '0 && is_sign) begin
          if (pos_r == start_r && start_r != '0) begin
            err_nxt = ptsu_pkg::ST_MALFORMED;
          end else begin
            rec.term_from     = start_r;
            rec.term_to       = ptsu_pkg::TO_W'(pos_r - 1'b1);
            rec.term_negative = neg_r;
            rec.term_depth    = tdep_r;
            p.a               = rec;
            p.cnt             = 2'd1;
            if (tdep_r > deep_r) begin
              deep_nxt = tdep_r;
            end
            start_nxt = pos_r + 1'b1;
            neg_nxt   = (in_ch == ptsu_pkg::CH_MINUS);
            tdep_nxt  = '0;
          end
        end
        if (err_nxt == ptsu_pkg::ST_OK) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      if (err_nxt == ptsu_pkg::ST_OK && in_last) begin
        if (lvl_nxt != '0) begin
          err_nxt = ptsu_pkg::ST_MALFORMED;
        end else begin
          wd = (tdep_nxt > deep_nxt) ? tdep_nxt : deep_nxt;
          rec.term_from     = start_nxt;
          rec.term_to       = ptsu_pkg::TO_W'(pos_nxt - 1'b1);
          rec.term_negative = neg_nxt;
          rec.term_depth    = tdep_nxt;
          rec.word_done     = 1'b1;
          rec.status        = ptsu_pkg::ST_OK;
          rec.word_depth    = wd;
          if (p.cnt == 2'd0) begin
            p.a   = rec;
            p.cnt = 2'd1;
          end else begin
            p.b   = rec;
            p.cnt = 2'd2;
          end
        end
      end
    end
    if (in_last) begin
      if (err_nxt != ptsu_pkg::ST_OK) begin
        rec           = '0;
        rec.word_done = 1'b1;
        rec.status    = err_nxt;
        if (p.cnt == 2'd0) begin
          p.a   = rec;
          p.cnt = 2'd1;
        end else begin
          p.b   = rec;
          p.cnt = 2'd2;
        end
      end
      pos_nxt   = '0;
      lvl_nxt   = '0;
      start_nxt = '0;
      neg_nxt   = 1'b0;
      tdep_nxt  = '0;
      deep_nxt  = '0;
      err_nxt   = ptsu_pkg::ST_OK;
    end
  end

  always_comb begin
    push = p;
    if (!accept) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      lvl_r   <= '0;
      start_r <= '0;
      neg_r   <= 1'b0;
      tdep_r  <= '0;
      deep_r  <= '0;
      err_r   <= ptsu_pkg::ST_OK;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      lvl_r   <= lvl_nxt;
      start_r <= start_nxt;
      neg_r   <= neg_nxt;
      tdep_r  <= tdep_nxt;
      deep_r  <= deep_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ----- hw/rtl/ptsu_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsu_queue
// Short result queue that takes up to two records per cycle and gives one.
// ----------------------------------------------------------------------------
module ptsu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  ptsu_pkg::push_t push,
  output logic            room,
  output logic            q_valid,
  output ptsu_pkg::rec_t  q_head,
  input  logic            pop
);

  ptsu_pkg::rec_t              mem_r [ptsu_pkg::QDEPTH];
  logic [ptsu_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [ptsu_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [ptsu_pkg::QCW-1:0]    cnt_r, cnt_nxt;

  assign room    = cnt_r <= ptsu_pkg::QCW'(ptsu_pkg::QDEPTH - 2);
  assign q_valid = cnt_r != '0;
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + ptsu_pkg::QAW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + ptsu_pkg::QAW'(pop);
    cnt_nxt    = cnt_r + ptsu_pkg::QCW'(push.cnt) - ptsu_pkg::QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.a;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_r + 1'b1] <= push.b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/ptsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsu_back
// Output register stage that moves queued records onto the result channel.
// ----------------------------------------------------------------------------
module ptsu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ptsu_pkg::rec_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output ptsu_pkg::rec_t out_rec
);

  logic           valid_r;
  ptsu_pkg::rec_t rec_r;
  logic           load;

  assign load      = !valid_r || !out_stall;
  assign pop       = q_valid && load;
  assign out_valid = valid_r;
  assign out_rec   = rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= q_head;
    end
  end

endmodule

// ----- hw/rtl/polynomial_term_splitter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polynomial_term_splitter_unit
// Splits an expression word into additive terms at top-level signs and
// reports bounds, sign and nesting depth of each term.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall   in_ch, in_last
//   out_      output     out_valid / out_stall term fields, word_done, status
//
// One character is taken per cycle while in_stall is low; the front scan state
// is registered. The first result of a request is written into a four-entry
// queue and then loaded into the output register before it is presented, and
// a second result of the same request follows it out of the queue. Reset is
// synchronous and clears all scan state and the queue. Input stalls only when
// the queue has fewer than two free entries.
// ----------------------------------------------------------------------------
module polynomial_term_splitter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_term_from,
  output logic [9:0]  out_term_to,
  output logic        out_term_negative,
  output logic [7:0]  out_term_depth,
  output logic        out_word_done,
  output logic [1:0]  out_status,
  output logic [7:0]  out_word_depth
);

  ptsu_pkg::push_t push;
  ptsu_pkg::rec_t  q_head;
  ptsu_pkg::rec_t  out_rec;
  logic            room;
  logic            q_valid;
  logic            pop;

  ptsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .room     (room),
    .push     (push)
  );

  ptsu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .room    (room),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop)
  );

  ptsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rec   (out_rec)
  );

  assign out_term_from     = out_rec.term_from;
  assign out_term_to       = out_rec.term_to;
  assign out_term_negative = out_rec.term_negative;
  assign out_term_depth    = out_rec.term_depth;
  assign out_word_done     = out_rec.word_done;
  assign out_status        = out_rec.status;
  assign out_word_depth    = out_rec.word_depth;

endmodule

// ----- hw/rtl/ptsu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptsu_checker
// Port-level checks of the term splitter, attached to the top level.
// ----------------------------------------------------------------------------
module ptsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] out_term_from,
  input logic [9:0]  out_term_to,
  input logic        out_term_negative,
  input logic [7:0]  out_term_depth,
  input logic        out_word_done,
  input logic [1:0]  out_status,
  input logic [7:0]  out_word_depth
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_term_from) &&
      $stable(out_term_to) && $stable(out_status) && $stable(out_word_done))
    else $error("result changed while stalled");

  a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word_done |-> out_status == ptsu_pkg::ST_OK &&
      out_word_depth == 8'd0)
    else $error("partial result carries word fields");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ptsu_pkg::ST_OK |-> out_word_done &&
      out_term_from == 11'd0 && out_term_to == 10'd0 && out_term_depth == 8'd0 &&
      out_word_depth == 8'd0 && !out_term_negative)
    else $error("error result carries term fields");

  a_word_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_done && out_status == ptsu_pkg::ST_OK |->
      out_word_depth >= out_term_depth)
    else $error("word depth below final term depth");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

endmodule

bind polynomial_term_splitter_unit ptsu_checker u_ptsu_checker (.*);
